@@ hdl/sfec_pkg.sv @@
// ----------------------------------------------------------------------------
// sfec_pkg
// Shared types and constants for the repair-count search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfec_pkg;

   localparam int MAX_PKTS  = 64;
   localparam int FRAC_W    = 32;                  // fraction bits of a probability
   localparam int PROB_W    = FRAC_W + 1;          // holds 0 .. ONE inclusive
   localparam int ADDR_W    = $clog2(MAX_PKTS + 1);
   localparam int MEM_DEPTH = MAX_PKTS + 1;
   localparam int ACC_W     = FRAC_W + 8;          // n*full plus weighted partial terms
   localparam int CNT_W     = 7;                   // packet counts up to MAX_PKTS
   localparam int PROD_W    = 2 * PROB_W;

   localparam logic [15:0]       TARGET_CAP = 16'd65470;
   localparam logic [PROB_W-1:0] FRAC_ONE   = PROB_W'(1) << FRAC_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TOTAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PROB = 2'd1;

   typedef struct packed {
      logic [15:0] erasure_prob;
      logic [5:0]  source_count;
   } req_type;

   typedef struct packed {
      logic [6:0]  send_count;
      logic [16:0] achieved_prob;
      logic        unreachable;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ROW0,
      CMD_READ_CUR,
      CMD_MUL_P,
      CMD_MUL_Q,
      CMD_WRITE_ROW,
      CMD_FULL_ADD,
      CMD_MUL_N,
      CMD_ACC_SET,
      CMD_READ_PART,
      CMD_INNER,
      CMD_MUL_SRC,
      CMD_MUL_IDX,
      CMD_ACC_ADD,
      CMD_DIV_START,
      CMD_RESULT
   } cmd_op_type;

   typedef enum logic [1:0] {
      RES_BYPASS,
      RES_NONE,
      RES_EVAL
   } res_kind_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [ADDR_W-1:0]   addr_a;    // current row / source row address
      logic [ADDR_W-1:0]   addr_b;    // repair row address
      logic                zero_old;  // top entry of the previous row reads as zero
      logic                first;     // entry zero has no lower neighbor
      logic                wr_src;
      logic                wr_rep;
      logic                use_rep;
      logic [5:0]          idx;
      logic [5:0]          n;
      res_kind_type        res_kind;
      logic [CNT_W-1:0]    send;
      logic                fail;
   } cmd_type;

   typedef struct packed {
      logic no_repair;
      logic hit;
      logic div_done;
   } stat_type;

endpackage

`default_nettype wire

@@ hdl/sfec_div.sv @@
// ----------------------------------------------------------------------------
// sfec_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfec_div
   import sfec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] dividend,
   input  wire logic [5:0]       divisor,
   output logic      [ACC_W-1:0] quot,
   output logic                  done
);

   localparam int CW = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] quot_ff, quot_in;
   logic [5:0]       rem_ff, rem_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             done_ff, done_in;
   logic [6:0]       shifted;
   logic             take;

   always_comb begin
      shifted  = {rem_ff, quot_ff[ACC_W-1]};
      take     = (shifted >= {1'b0, divisor});
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         count_in = CW'(ACC_W);
      end else if (count_ff != '0) begin
         rem_in   = take ? 6'(shifted - {1'b0, divisor}) : shifted[5:0];
         quot_in  = {quot_ff[ACC_W-2:0], take};
         count_in = count_ff - CW'(1);
         done_in  = (count_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

@@ hdl/sfec_dp.sv @@
// ----------------------------------------------------------------------------
// sfec_dp
// Datapath: row memories, shared multiplier, accumulators, divider, result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfec_dp
   import sfec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [15:0] erasure_prob,
   input  wire logic [15:0] target_prob,
   output stat_type         stat,
   output rsp_type          rsp_payload
);

   logic [PROB_W-1:0] cur_mem [0:MEM_DEPTH-1];
   logic [PROB_W-1:0] src_mem [0:MEM_DEPTH-1];
   logic [PROB_W-1:0] rep_mem [0:MEM_DEPTH-1];

   logic [15:0]       per_ff, tgt16_ff;
   logic [PROB_W-1:0] p_ff, q_ff, tgt_ff;
   logic [PROB_W-1:0] cur_rd_ff, src_rd_ff, rep_rd_ff;
   logic [PROB_W-1:0] old_ff, prev_ff, part_ff, full_ff, inner_ff, src_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [PROD_W-1:0] prod_ff;
   rsp_type           res_ff;

   logic [PROB_W-1:0] old_val, prod_hi, mul_a, mul_b, new_val;
   logic [PROB_W:0]   inner_sum;
   logic [15:0]       tgt16;
   logic [ACC_W-1:0]  quot;
   logic              div_done;
   logic              cur_we;
   logic [ADDR_W-1:0] cur_waddr;
   logic [PROB_W-1:0] cur_wdata;

   assign tgt16     = (target_prob > TARGET_CAP) ? TARGET_CAP : target_prob;
   assign old_val   = cmd.zero_old ? '0 : cur_rd_ff;
   assign prod_hi   = prod_ff[PROD_W-2:FRAC_W];
   assign new_val   = PROB_W'(part_ff + prod_hi);
   assign inner_sum = {1'b0, inner_ff} + {1'b0, (cmd.use_rep ? rep_rd_ff : '0)};

   always_comb begin
      case (cmd.op)
         CMD_MUL_P:   begin mul_a = old_val;                      mul_b = p_ff;     end
         CMD_MUL_Q:   begin mul_a = cmd.first ? '0 : prev_ff;     mul_b = q_ff;     end
         CMD_MUL_N:   begin mul_a = PROB_W'(cmd.n);               mul_b = full_ff;  end
         CMD_MUL_SRC: begin mul_a = src_ff;                       mul_b = inner_ff; end
         CMD_MUL_IDX: begin mul_a = PROB_W'(cmd.idx);             mul_b = prod_hi;  end
         default:     begin mul_a = '0;                           mul_b = '0;       end
      endcase
   end

   // one write port on the working row: seed or row update
   always_comb begin
      cur_we    = (cmd.op == CMD_ROW0) || (cmd.op == CMD_WRITE_ROW);
      cur_waddr = (cmd.op == CMD_ROW0) ? '0 : cmd.addr_a;
      cur_wdata = (cmd.op == CMD_ROW0) ? FRAC_ONE : new_val;
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (cmd.op == CMD_WRITE_ROW && cmd.wr_src) begin
         src_mem[cmd.addr_a] <= new_val;
      end
      if (cmd.op == CMD_WRITE_ROW && cmd.wr_rep) begin
         rep_mem[cmd.addr_a] <= new_val;
      end
      cur_rd_ff <= cur_mem[cmd.addr_a];
      src_rd_ff <= src_mem[cmd.addr_a];
      rep_rd_ff <= rep_mem[cmd.addr_b];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            per_ff   <= erasure_prob;
            tgt16_ff <= tgt16;
            p_ff     <= {1'b0, erasure_prob, 16'b0};
            q_ff     <= FRAC_ONE - {1'b0, erasure_prob, 16'b0};
            tgt_ff   <= {1'b0, tgt16, 16'b0};
         end
         CMD_ROW0:      full_ff <= '0;
         CMD_MUL_P: begin
            old_ff  <= old_val;
            prod_ff <= mul_a * mul_b;
         end
         CMD_MUL_Q: begin
            part_ff <= prod_hi;
            prod_ff <= mul_a * mul_b;
         end
         CMD_WRITE_ROW: prev_ff <= old_ff;
         CMD_FULL_ADD:  full_ff <= PROB_W'(full_ff + cur_rd_ff);
         CMD_MUL_N,
         CMD_MUL_SRC,
         CMD_MUL_IDX:   prod_ff <= mul_a * mul_b;
         CMD_ACC_SET: begin
            acc_ff   <= prod_ff[ACC_W-1:0];
            inner_ff <= '0;
         end
         CMD_INNER: begin
            inner_ff <= inner_sum[PROB_W-1:0];
            src_ff   <= src_rd_ff;
         end
         CMD_ACC_ADD:   acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
         CMD_RESULT: begin
            res_ff.send_count  <= cmd.send;
            res_ff.unreachable <= cmd.fail;
            case (cmd.res_kind)
               RES_BYPASS: res_ff.achieved_prob <= 17'h10000 - {1'b0, per_ff};
               RES_EVAL:   res_ff.achieved_prob <= quot[FRAC_W:FRAC_W-16];
               default:    res_ff.achieved_prob <= '0;
            endcase
         end
         default: ;
      endcase
   end

   sfec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == CMD_DIV_START),
      .dividend (acc_ff),
      .divisor  (cmd.n),
      .quot     (quot),
      .done     (div_done)
   );

   assign stat.no_repair = ({1'b0, tgt16_ff} < (17'h10000 - {1'b0, per_ff}));
   assign stat.hit       = (quot >= ACC_W'(tgt_ff));
   assign stat.div_done  = div_done;
   assign rsp_payload    = res_ff;

endmodule

`default_nettype wire

@@ hdl/sfec_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfec_ctrl
// Sequencer: walks the rows, sums and search steps; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfec_ctrl
   import sfec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [5:0] source_count,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [6:0] max_total,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_ROW0, S_RD, S_MP, S_MQ, S_WR, S_FRD, S_FADD, S_FMUL,
      S_FACC, S_PRD, S_PIN, S_PM1, S_PM2, S_PACC, S_DIV, S_DWAIT, S_CHECK, S_OUT
   } state_type;

   state_type        state_ff;
   logic [5:0]       n_ff, m_ff;
   logic [CNT_W-1:0] k_ff, limit_ff, t_ff, i_ff, send_ff;
   res_kind_type     kind_ff;
   logic             fail_ff, rsp_valid_ff;

   logic [CNT_W-1:0] total;
   logic             more_k, out_free;

   assign total    = CNT_W'({1'b0, n_ff} + k_ff);
   assign more_k   = ({2'b0, n_ff} + {1'b0, k_ff} + 8'd1) < {1'b0, limit_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.op       = CMD_NONE;
      cmd.res_kind = kind_ff;
      cmd.send     = send_ff;
      cmd.fail     = fail_ff;
      cmd.n        = n_ff;
      cmd.idx      = 6'(n_ff - 6'd1 - m_ff);
      cmd.addr_a   = (state_ff == S_PRD) ? ADDR_W'(cmd.idx) : i_ff;
      cmd.addr_b   = ADDR_W'(m_ff);
      cmd.zero_old = (i_ff == t_ff);
      cmd.first    = (i_ff == '0);
      cmd.wr_src   = (t_ff == CNT_W'(n_ff));
      cmd.wr_rep   = (t_ff == k_ff);
      cmd.use_rep  = (CNT_W'(m_ff) <= k_ff);
      unique case (state_ff)
         S_IDLE:  cmd.op = (req_valid) ? CMD_LOAD : CMD_NONE;
         S_ROW0:  cmd.op = CMD_ROW0;
         S_RD:    cmd.op = CMD_READ_CUR;
         S_MP:    cmd.op = CMD_MUL_P;
         S_MQ:    cmd.op = CMD_MUL_Q;
         S_WR:    cmd.op = CMD_WRITE_ROW;
         S_FRD:   cmd.op = CMD_READ_CUR;
         S_FADD:  cmd.op = CMD_FULL_ADD;
         S_FMUL:  cmd.op = CMD_MUL_N;
         S_FACC:  cmd.op = CMD_ACC_SET;
         S_PRD:   cmd.op = CMD_READ_PART;
         S_PIN:   cmd.op = CMD_INNER;
         S_PM1:   cmd.op = CMD_MUL_SRC;
         S_PM2:   cmd.op = CMD_MUL_IDX;
         S_PACC:  cmd.op = CMD_ACC_ADD;
         S_DIV:   cmd.op = CMD_DIV_START;
         S_OUT:   cmd.op = out_free ? CMD_RESULT : CMD_NONE;
         default: cmd.op = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff     <= (source_count == '0) ? 6'd1 : source_count;
                  limit_ff <= (max_total > CNT_W'(MAX_PKTS)) ? CNT_W'(MAX_PKTS) : max_total;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               if (stat.no_repair) begin
                  kind_ff  <= RES_BYPASS;
                  send_ff  <= CNT_W'(n_ff);
                  fail_ff  <= 1'b0;
                  state_ff <= S_OUT;
               end else if (({2'b0, n_ff} + 8'd1) < {1'b0, limit_ff}) begin
                  k_ff     <= CNT_W'(1);
                  state_ff <= S_ROW0;
               end else begin
                  kind_ff  <= RES_NONE;
                  send_ff  <= CNT_W'({1'b0, n_ff} + 7'd1);
                  fail_ff  <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_ROW0: begin
               t_ff     <= CNT_W'(1);
               i_ff     <= '0;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_MP;
            S_MP: state_ff <= S_MQ;
            S_MQ: state_ff <= S_WR;
            S_WR: begin
               if (i_ff == t_ff) begin
                  if (t_ff == total) begin
                     i_ff     <= CNT_W'(n_ff);
                     state_ff <= S_FRD;
                  end else begin
                     t_ff     <= t_ff + CNT_W'(1);
                     i_ff     <= '0;
                     state_ff <= S_RD;
                  end
               end else begin
                  i_ff     <= i_ff + CNT_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_FRD: state_ff <= S_FADD;
            S_FADD: begin
               if (i_ff == total) begin
                  state_ff <= S_FMUL;
               end else begin
                  i_ff     <= i_ff + CNT_W'(1);
                  state_ff <= S_FRD;
               end
            end
            S_FMUL: state_ff <= S_FACC;
            S_FACC: begin
               m_ff     <= '0;
               state_ff <= S_PRD;
            end
            S_PRD: state_ff <= S_PIN;
            S_PIN: state_ff <= S_PM1;
            S_PM1: state_ff <= S_PM2;
            S_PM2: state_ff <= S_PACC;
            S_PACC: begin
               if (m_ff == n_ff - 6'd1) begin
                  state_ff <= S_DIV;
               end else begin
                  m_ff     <= m_ff + 6'd1;
                  state_ff <= S_PRD;
               end
            end
            S_DIV: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (stat.hit) begin
                  kind_ff  <= RES_EVAL;
                  send_ff  <= total;
                  fail_ff  <= 1'b0;
                  state_ff <= S_OUT;
               end else if (more_k) begin
                  k_ff     <= k_ff + CNT_W'(1);
                  state_ff <= S_ROW0;
               end else begin
                  kind_ff  <= RES_EVAL;
                  send_ff  <= limit_ff;
                  fail_ff  <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/systematic_fec_repair_count_search_top.sv @@
// ----------------------------------------------------------------------------
// systematic_fec_repair_count_search_top
// Picks the fewest total packets N+K for a systematic erasure code.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries erasure_prob (loss probability, 1/65536 units) and
//   source_count N. One response returns send_count, achieved_prob and the
//   unreachable flag. Both channels use valid/stall; a request is taken when
//   req_valid is high and req_stall is low, a response when rsp_valid is high
//   and rsp_stall is low.
//   The csr port writes max_total (index 0) and target_prob (index 1); write
//   only while no request is in flight.
// Sequencing:
//   One request at a time. In the no-repair case the search is skipped and
//   the result goes straight to the output stage. For each repair count K
//   tried, the single shared multiplier builds the binomial rows one entry
//   at a time (read, multiply by p, multiply by q, write), and the 40-step
//   bit-serial divider then divides the weighted sum by N.
// Reset:
//   Synchronous; registers return to max_total=64, target_prob=65470, and
//   the output holds no response.
// Stall:
//   A finished response waits in the output register; a new request is taken
//   meanwhile, and its result waits until the held response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module systematic_fec_repair_count_search_top
   import sfec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   logic [6:0]  max_total_ff;
   logic [15:0] target_prob_ff;
   cmd_type     cmd;
   stat_type    stat;

   // configuration registers; unknown indexes drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff   <= 7'd64;
         target_prob_ff <= 16'd65470;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_TOTAL:   max_total_ff   <= csr_wdata[6:0];
            CSR_TARGET_PROB: target_prob_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfec_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .source_count (req_payload.source_count),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .max_total    (max_total_ff),
      .stat         (stat),
      .cmd          (cmd)
   );

   sfec_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .erasure_prob (req_payload.erasure_prob),
      .target_prob  (target_prob_ff),
      .stat         (stat),
      .rsp_payload  (rsp_payload)
   );

   // a taken request always makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken but block not busy");

   // total count stays within the packet limit
   a_send_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.send_count != 7'd0 && rsp_payload.send_count <= 7'd64)
      else $error("send_count out of range");

   // a met target always reports a nonzero fraction
   a_met_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.unreachable |-> rsp_payload.achieved_prob != 17'd0)
      else $error("target met with zero achieved_prob");

endmodule

`default_nettype wire

@@ verif/sfec_search_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfec_search_checker
// Watches the request, response and csr ports, predicts each response of the
// repair-count search and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sfec_search_checker
   import sfec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_payload,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   output int                        error_count,
   output int                        pending_count
);

   logic [6:0]  cfg_max_total;
   logic [15:0] cfg_target;
   rsp_type     expected_rsp_q[$];

   logic [63:0] row_all[0:MAX_PKTS];
   logic [63:0] row_n[0:MAX_PKTS];
   logic [63:0] row_k[0:MAX_PKTS];

   function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[95:32];
   endfunction

   // expected delivered fraction with n source and k repair packets
   function automatic logic [63:0] delivered(input int n, input int k,
                                             input logic [63:0] p, input logic [63:0] q);
      logic [63:0] full, acc, inner;
      int lim;
      full = 0;
      row_all[0] = 64'd1 << 32;
      for (int t = 1; t <= n + k; t++) begin
         row_all[t] = 0;
         for (int i = t; i >= 1; i--)
            row_all[i] = frac_mul(row_all[i], p) + frac_mul(row_all[i-1], q);
         row_all[0] = frac_mul(row_all[0], p);
         if (t == n) for (int i = 0; i <= t; i++) row_n[i] = row_all[i];
         if (t == k) for (int i = 0; i <= t; i++) row_k[i] = row_all[i];
      end
      for (int i = n; i <= n + k; i++) full += row_all[i];
      acc = 64'(n) * full;
      for (int i = 0; i < n; i++) begin
         lim = n - i - 1;
         if (lim > k) lim = k;
         inner = 0;
         for (int j = 0; j <= lim; j++) inner += row_k[j];
         acc += 64'(i) * frac_mul(row_n[i], inner);
      end
      return acc / 64'(n);
   endfunction

   function automatic rsp_type search_send_count(input req_type r);
      rsp_type     res;
      int          n, lim, k;
      logic [15:0] tgt16;
      logic [63:0] p, q, tgt, ps;
      bit          tried;
      n     = (r.source_count == 0) ? 1 : int'(r.source_count);
      tgt16 = (cfg_target > TARGET_CAP) ? TARGET_CAP : cfg_target;
      ps    = 0;
      tried = 0;
      if (17'(tgt16) < 17'd65536 - 17'(r.erasure_prob)) begin
         res.send_count    = 7'(n);
         res.achieved_prob = 17'd65536 - 17'(r.erasure_prob);
         res.unreachable   = 1'b0;
         return res;
      end
      lim = (cfg_max_total > MAX_PKTS) ? MAX_PKTS : int'(cfg_max_total);
      p   = 64'(r.erasure_prob) << 16;
      q   = (64'd1 << 32) - p;
      tgt = 64'(tgt16) << 16;
      for (k = 1; k < lim - n; k++) begin
         ps    = delivered(n, k, p, q);
         tried = 1;
         if (ps >= tgt) break;
      end
      res.send_count    = 7'(n + k);
      res.achieved_prob = tried ? 17'(ps >> 16) : 17'd0;
      res.unreachable   = (!tried || ps < tgt);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_max_total = 7'd64;
         cfg_target    = 16'd65470;
         expected_rsp_q.delete();
         error_count   = 0;
      end else begin
         if (csr_write && csr_index == CSR_MAX_TOTAL)   cfg_max_total = csr_wdata[6:0];
         if (csr_write && csr_index == CSR_TARGET_PROB) cfg_target    = csr_wdata;
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(search_send_count(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response %p", $realtime, rsp_payload);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.send_count !== want.send_count) begin
                  error_count++;
                  $display("%0t: send_count expected %0d actual %0d", $realtime,
                           want.send_count, rsp_payload.send_count);
               end
               if (rsp_payload.achieved_prob !== want.achieved_prob) begin
                  error_count++;
                  $display("%0t: achieved_prob expected %0d actual %0d", $realtime,
                           want.achieved_prob, rsp_payload.achieved_prob);
               end
               if (rsp_payload.unreachable !== want.unreachable) begin
                  error_count++;
                  $display("%0t: unreachable expected %0d actual %0d", $realtime,
                           want.unreachable, rsp_payload.unreachable);
               end
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

`default_nettype wire

@@ verif/tb_systematic_fec_repair_count_search_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_systematic_fec_repair_count_search_top
// Drives requests and csr settings into the repair-count search block with
// random idling on both channels; a checker beside the block predicts every
// response and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_systematic_fec_repair_count_search_top;
   import sfec_pkg::*;

   localparam int IDLE_LIMIT = 1000000;   // cycles with no handshake at all

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MAX_TOTAL;
   logic [15:0]          csr_wdata = '0;

   int  error_count, pending_count;
   int  idle_cycles = 0;
   int  hold_left = 0;        // receiver stall cycles still to go
   int  long_hold = 0;        // long receiver hold-off requested by stimulus
   bit  quiet = 0;            // no idling in the closing part of the run

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   systematic_fec_repair_count_search_top u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload, .csr_write, .csr_index, .csr_wdata
   );

   sfec_search_checker u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload, .csr_write, .csr_index, .csr_wdata,
      .error_count, .pending_count
   );

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   always @(negedge clock) begin
      if (long_hold > 0) begin
         hold_left = long_hold;
         long_hold = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: count cycles in which no handshake of either channel happens.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[systematic_fec_repair_count_search_top] ERROR");
         $finish;
      end
   end

   // Offer one request and hold it until taken; optionally drop valid for a burst.
   task automatic send_request(input logic [15:0] prob, input logic [5:0] count);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= '{erasure_prob: prob, source_count: count};
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19) - 1) @(negedge clock);
      end
   endtask

   // Wait until every response is back, then let the block settle before a write.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Random request: source count capped so the search stays short.
   task automatic random_request(input int prob_max, input int count_max);
      logic [5:0] count;
      count = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, count_max));
      send_request(16'($urandom_range(0, prob_max)), count);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: no-repair bypass, zero count, no K evaluated, exhaustion.
      send_request(16'd0, 6'd1);
      send_request(16'd0, 6'd0);
      send_request(16'd65535, 6'd63);
      send_request(16'd1000, 6'd1);
      send_request(16'd1000, 6'd8);
      send_request(16'd100, 6'd63);
      send_request(16'd66, 6'd40);
      send_request(16'd32768, 6'd4);
      send_request(16'd65535, 6'd1);      // whole search runs out at the limit
      repeat (15) random_request(4000, 16);

      // Pause the sender until everything has come back.
      drain();

      // Small limit, lower target; full range of loss probability.
      write_csr(CSR_MAX_TOTAL, 16'd12);
      write_csr(CSR_TARGET_PROB, 16'd60000);
      repeat (10) random_request(65535, 11);
      // Hold the receiver off long enough for the input side to back up.
      @(posedge clock);
      long_hold = 400;
      repeat (6) send_request(16'd0, 6'($urandom_range(1, 63)));
      repeat (10) random_request(65535, 11);

      // Smallest legal limit, zero target: everything bypasses.
      write_csr(CSR_MAX_TOTAL, 16'd2);
      write_csr(CSR_TARGET_PROB, 16'd0);
      send_request(16'd65535, 6'd63);
      repeat (5) random_request(65535, 63);

      // Limit below two, target above the cap.
      write_csr(CSR_MAX_TOTAL, 16'd1);
      write_csr(CSR_TARGET_PROB, 16'd65535);
      send_request(16'd0, 6'd1);
      send_request(16'd65535, 6'd0);
      write_csr(CSR_MAX_TOTAL, 16'd0);
      repeat (4) random_request(65535, 63);

      // Unused register indexes must not disturb anything.
      write_csr(2'd2, 16'hFFFF);
      write_csr(2'd3, 16'h0000);

      // Limit saturates to the packet maximum.
      write_csr(CSR_MAX_TOTAL, 16'hFFFF);
      write_csr(CSR_TARGET_PROB, 16'd50000);
      repeat (12) random_request(8000, 20);

      // Closing part: no idling on either side.
      write_csr(CSR_MAX_TOTAL, 16'($urandom_range(14, 22)));
      write_csr(CSR_TARGET_PROB, 16'($urandom_range(0, 65535)));
      quiet = 1;
      repeat (25) random_request(65535, 18);

      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("[systematic_fec_repair_count_search_top] OK");
      else
         $display("[systematic_fec_repair_count_search_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
